[src/streaming_stats_aggregator_core_assert.svh]
// assertion macros used by the aggregator back end (ssa_back)
`ifndef STREAMING_STATS_AGGREGATOR_CORE_ASSERT_SVH
`define STREAMING_STATS_AGGREGATOR_CORE_ASSERT_SVH

// same-cycle implication, clocked by i_clk, off while i_rst_n is low
`define SSA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ssa_pkg.sv]
// shared types and constants of the statistics aggregator
`default_nettype none
package ssa_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COUNT_BITS_DEF = 16;
    localparam int TOTAL_BITS     = 48;
    localparam int SQ_BITS        = 64;
    localparam int OUT_BITS       = 48;
    localparam int MODE_BITS      = 3;
    localparam int QUEUE_DEPTH    = 4;
    localparam int RECIP_SHIFT    = 24;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_SUM   = 3'd0,
        MODE_MIN   = 3'd1,
        MODE_MAX   = 3'd2,
        MODE_MEAN  = 3'd3,
        MODE_STD   = 3'd4,
        MODE_RSUM  = 3'd5,
        MODE_RMEAN = 3'd6,
        MODE_NONE  = 3'd7
    } t_mode;

    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_SUM   = 4'd1,
        OP_MEAN  = 4'd2,
        OP_STD   = 4'd3,
        OP_MIN   = 4'd4,
        OP_MAX   = 4'd5,
        OP_RSUM  = 4'd6,
        OP_RMEAN = 4'd7,
        OP_ZERO  = 4'd8
    } t_op;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] aggregate;
        logic                       zero_divisor;
        logic                       saturated;
    } t_out_item;

    typedef struct packed {
        t_op                           op;
        t_mode                         mode;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } t_entry;

endpackage
`default_nettype wire

[src/ssa_front.sv]
// front end: mode register, item intake and classification
`default_nettype none
module ssa_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_wdata,
    input  wire logic              i_push,
    input  wire ssa_pkg::t_in_item i_item,
    input  wire logic              i_q_full,
    output      logic              o_q_wr,
    output      ssa_pkg::t_entry   o_entry
);
    import ssa_pkg::*;

    t_mode r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SUM;
        end else if (i_cfg_we) begin
            r_mode <= t_mode'(i_cfg_wdata);
        end
    end

    always_comb begin
        o_entry.mode   = r_mode;
        o_entry.sample = i_item.sample;
        o_entry.last   = i_item.last;
        case (r_mode)
            MODE_SUM:   o_entry.op = OP_SUM;
            MODE_MEAN:  o_entry.op = OP_MEAN;
            MODE_STD:   o_entry.op = OP_STD;
            MODE_MIN:   o_entry.op = OP_MIN;
            MODE_MAX:   o_entry.op = OP_MAX;
            MODE_RSUM:  o_entry.op = (i_item.sample == '0) ? OP_ZERO : OP_RSUM;
            MODE_RMEAN: o_entry.op = (i_item.sample == '0) ? OP_ZERO : OP_RMEAN;
            default:    o_entry.op = OP_NONE;
        endcase
    end

    assign o_q_wr = i_push && !i_q_full;

endmodule
`default_nettype wire

[src/ssa_queue.sv]
// small queue of classified items between front and back
`default_nettype none
module ssa_queue #(
    parameter int DEPTH = ssa_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr,
    input  wire ssa_pkg::t_entry i_wdata,
    input  wire logic            i_rd,
    output      ssa_pkg::t_entry o_rdata,
    output      logic            o_full,
    output      logic            o_empty
);
    import ssa_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic            do_wr;
    logic            do_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[src/ssa_div.sv]
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module ssa_div #(
    parameter int DIV_W = ssa_pkg::SAMPLE_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [ssa_pkg::SQ_BITS-1:0] i_dividend,
    input  wire logic [DIV_W-1:0]            i_divisor,
    output      logic                        o_busy,
    output      logic                        o_done,
    output      logic [ssa_pkg::SQ_BITS-1:0] o_quot
);
    import ssa_pkg::*;

    localparam int NW = $clog2(SQ_BITS);

    logic [DIV_W:0]     r_rem;
    logic [SQ_BITS-1:0] r_quo;
    logic [DIV_W-1:0]   r_dvs;
    logic [NW-1:0]      r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [DIV_W:0]     sh;
    logic               ge;

    assign sh     = {r_rem[DIV_W-1:0], r_quo[SQ_BITS-1]};
    assign ge     = (sh >= {1'b0, r_dvs});
    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? (sh - {1'b0, r_dvs}) : sh;
            r_quo <= {r_quo[SQ_BITS-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == NW'(SQ_BITS - 1));
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == NW'(SQ_BITS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule
`default_nettype wire

[src/ssa_sqrt.sv]
// iterative floor square root, one result bit per cycle
`default_nettype none
module ssa_sqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [ssa_pkg::SQ_BITS-1:0]   i_value,
    output      logic                          o_busy,
    output      logic                          o_done,
    output      logic [ssa_pkg::SQ_BITS/2-1:0] o_root
);
    import ssa_pkg::*;

    localparam int RW = SQ_BITS / 2;
    localparam int NW = $clog2(RW);

    logic [SQ_BITS-1:0] r_v;
    logic [SQ_BITS-1:0] r_r;
    logic [SQ_BITS-1:0] r_bit;
    logic [NW-1:0]      r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [SQ_BITS-1:0] trial;

    assign trial  = r_r + r_bit;
    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_r[RW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_v   <= i_value;
            r_r   <= '0;
            r_bit <= SQ_BITS'(1) << (SQ_BITS - 2);
        end else if (r_busy) begin
            if (r_v >= trial) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == NW'(RW - 1));
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == NW'(RW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule
`default_nettype wire

[src/ssa_back.sv]
// back end: accumulators, group-end sequencer and result register
`default_nettype none
`include "streaming_stats_aggregator_core_assert.svh"
module ssa_back #(
    parameter int COUNT_BITS = ssa_pkg::COUNT_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ssa_pkg::t_entry    i_entry,
    input  wire logic               i_q_empty,
    output      logic               o_q_rd,
    input  wire logic               i_pop,
    output      logic               o_out_valid,
    output      ssa_pkg::t_out_item o_result
);
    import ssa_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int TB    = TOTAL_BITS;
    localparam int MW    = SB;
    localparam int MB    = SB + 8;
    localparam int DIV_W = (COUNT_BITS > SB) ? COUNT_BITS : SB;
    localparam logic [SQ_BITS-1:0] MLIM = SQ_BITS'(1) << (SB + 7);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_SQ    = 14'b00000000000010,
        S_RDIV  = 14'b00000000000100,
        S_FIN   = 14'b00000000001000,
        S_MDIV  = 14'b00000000010000,
        S_SDIV1 = 14'b00000000100000,
        S_SDIV2 = 14'b00000001000000,
        S_M1    = 14'b00000010000000,
        S_M2    = 14'b00000100000000,
        S_M3    = 14'b00001000000000,
        S_M4    = 14'b00010000000000,
        S_VAR   = 14'b00100000000000,
        S_SQRT  = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } t_state;

    t_state                 r_state, n_state;
    logic signed [TB-1:0]   r_total, n_total;
    logic [SQ_BITS-1:0]     r_sqtot, n_sqtot;
    logic [COUNT_BITS-1:0]  r_count, n_count;
    logic signed [SB-1:0]   r_ext, n_ext;
    logic                   r_seen, n_seen;
    logic                   r_zf, n_zf;
    logic                   r_of, n_of;
    logic                   r_last, n_last;
    t_mode                  r_fmode, n_fmode;
    logic                   r_neg, n_neg;
    logic [MB-1:0]          r_m, n_m;
    logic [SQ_BITS-1:0]     r_msq, n_msq;
    logic [SQ_BITS-1:0]     r_acc, n_acc;
    logic                   r_big, n_big;
    logic signed [TB-1:0]   r_agg, n_agg;
    logic [2*MW-1:0]        r_prod;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out, n_out;

    logic [MW-1:0]          mul_a, mul_b;
    logic [SB-1:0]          x_mag;
    logic [TB-1:0]          tot_mag;
    logic signed [TB-1:0]   x_scaled;
    logic signed [TB-1:0]   ext_scaled;

    logic                   div_start, div_busy, div_done;
    logic [SQ_BITS-1:0]     div_dividend, div_quot;
    logic [DIV_W-1:0]       div_divisor;
    logic                   sq_start, sq_busy, sq_done;
    logic [SQ_BITS-1:0]     sq_value;
    logic [SQ_BITS/2-1:0]   sq_root;

    function automatic logic [TB:0] sat_add(input logic [TB-1:0] t, input logic [TB-1:0] v);
        logic [TB:0] s;
        s = {t[TB-1], t} + {v[TB-1], v};
        if (s[TB] != s[TB-1]) begin
            return s[TB] ? {1'b1, 1'b1, {(TB-1){1'b0}}} : {1'b1, 1'b0, {(TB-1){1'b1}}};
        end
        return {1'b0, s[TB-1:0]};
    endfunction

    assign x_mag      = i_entry.sample[SB-1] ? (~i_entry.sample + 1'b1) : i_entry.sample;
    assign tot_mag    = r_total[TB-1] ? (~r_total + 1'b1) : r_total;
    assign x_scaled   = {{(TB-SB-8){i_entry.sample[SB-1]}}, i_entry.sample, 8'd0};
    assign ext_scaled = {{(TB-SB-8){r_ext[SB-1]}}, r_ext, 8'd0};

    ssa_div #(.DIV_W(DIV_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    ssa_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (sq_value),
        .o_busy  (sq_busy),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_comb begin
        logic [TB:0]      sa;
        logic [SQ_BITS:0] sqs;
        logic [SQ_BITS-1:0] vnum;
        logic [TB-1:0]    q48;

        n_state = r_state;   n_total = r_total;  n_sqtot = r_sqtot;
        n_count = r_count;   n_ext   = r_ext;    n_seen  = r_seen;
        n_zf    = r_zf;      n_of    = r_of;     n_last  = r_last;
        n_fmode = r_fmode;   n_neg   = r_neg;    n_m     = r_m;
        n_msq   = r_msq;     n_acc   = r_acc;    n_big   = r_big;
        n_agg   = r_agg;
        n_out   = r_out;
        n_out_valid  = r_out_valid && !i_pop;
        o_q_rd       = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        sq_start     = 1'b0;
        sq_value     = '0;
        sa           = '0;
        sqs          = '0;
        vnum         = '0;
        q48          = '0;

        case (r_state)
            S_IDLE: begin
                mul_a = x_mag;
                mul_b = x_mag;
                if (!i_q_empty) begin
                    o_q_rd  = 1'b1;
                    n_last  = i_entry.last;
                    n_fmode = i_entry.mode;
                    n_state = i_entry.last ? S_FIN : S_IDLE;
                    case (i_entry.op)
                        OP_SUM, OP_MEAN, OP_STD: begin
                            sa      = sat_add(r_total, x_scaled);
                            n_total = sa[TB-1:0];
                            if (sa[TB]) n_of = 1'b1;
                            if (i_entry.op != OP_SUM) begin
                                if (r_count != '1) n_count = r_count + 1'b1;
                                else               n_of    = 1'b1;
                            end
                            if (i_entry.op == OP_STD) n_state = S_SQ;
                        end
                        OP_MIN: begin
                            if (!r_seen || ($signed(i_entry.sample) < r_ext))
                                n_ext = i_entry.sample;
                            n_seen = 1'b1;
                        end
                        OP_MAX: begin
                            if (!r_seen || ($signed(i_entry.sample) > r_ext))
                                n_ext = i_entry.sample;
                            n_seen = 1'b1;
                        end
                        OP_RSUM, OP_RMEAN: begin
                            div_start    = 1'b1;
                            div_dividend = SQ_BITS'(1) << RECIP_SHIFT;
                            div_divisor  = DIV_W'(x_mag);
                            n_neg        = i_entry.sample[SB-1];
                            n_state      = S_RDIV;
                        end
                        OP_ZERO: n_zf = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_SQ: begin
                sqs = {1'b0, r_sqtot} + (SQ_BITS+1)'(r_prod);
                if (sqs[SQ_BITS]) begin
                    n_sqtot = '1;
                    n_of    = 1'b1;
                end else begin
                    n_sqtot = sqs[SQ_BITS-1:0];
                end
                n_state = r_last ? S_FIN : S_IDLE;
            end
            S_RDIV: begin
                if (div_done) begin
                    q48 = r_neg ? (~div_quot[TB-1:0] + 1'b1) : div_quot[TB-1:0];
                    sa  = sat_add(r_total, q48);
                    n_total = sa[TB-1:0];
                    if (sa[TB]) n_of = 1'b1;
                    if (r_fmode == MODE_RMEAN) begin
                        if (r_count != '1) n_count = r_count + 1'b1;
                        else               n_of    = 1'b1;
                    end
                    n_state = r_last ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                n_agg   = '0;
                n_state = S_OUT;
                case (r_fmode)
                    MODE_SUM, MODE_RSUM: n_agg = r_total;
                    MODE_MIN, MODE_MAX:  n_agg = r_seen ? ext_scaled : '0;
                    MODE_MEAN, MODE_RMEAN, MODE_STD: begin
                        if (r_count != '0) begin
                            div_start    = 1'b1;
                            div_dividend = SQ_BITS'(tot_mag);
                            div_divisor  = DIV_W'(r_count);
                            n_neg        = r_total[TB-1];
                            n_state      = (r_fmode == MODE_STD) ? S_SDIV1 : S_MDIV;
                        end
                    end
                    default: ;
                endcase
            end
            S_MDIV: begin
                if (div_done) begin
                    q48     = div_quot[TB-1:0];
                    n_agg   = r_neg ? (~q48 + 1'b1) : q48;
                    n_state = S_OUT;
                end
            end
            S_SDIV1: begin
                if (div_done) begin
                    n_m          = (div_quot > MLIM) ? MLIM[MB-1:0] : div_quot[MB-1:0];
                    div_start    = 1'b1;
                    div_dividend = r_sqtot;
                    div_divisor  = DIV_W'(r_count);
                    n_state      = S_SDIV2;
                end
            end
            S_SDIV2: begin
                if (div_done) begin
                    n_msq   = div_quot;
                    n_state = S_M1;
                end
            end
            S_M1: begin
                mul_a   = MW'(r_m[MB-1:16]);
                mul_b   = MW'(r_m[MB-1:16]);
                n_state = S_M2;
            end
            S_M2: begin
                mul_a   = MW'(r_m[MB-1:16]);
                mul_b   = MW'(r_m[15:0]);
                n_acc   = SQ_BITS'(r_prod) << 16;
                n_state = S_M3;
            end
            S_M3: begin
                mul_a   = MW'(r_m[15:0]);
                mul_b   = MW'(r_m[15:0]);
                n_acc   = r_acc + (SQ_BITS'(r_prod) << 1);
                n_state = S_M4;
            end
            S_M4: begin
                n_acc   = r_acc + SQ_BITS'(r_prod >> 16);
                n_state = S_VAR;
            end
            S_VAR: begin
                vnum     = (r_msq > r_acc) ? (r_msq - r_acc) : '0;
                n_big    = (vnum[SQ_BITS-1:48] != '0);
                sq_start = 1'b1;
                sq_value = (vnum[SQ_BITS-1:48] != '0) ? vnum : (vnum << 16);
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                if (sq_done) begin
                    n_agg   = r_big ? TB'({sq_root, 8'd0}) : TB'(sq_root);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid) begin
                    n_out_valid        = 1'b1;
                    n_out.aggregate    = r_agg;
                    n_out.zero_divisor = r_zf;
                    n_out.saturated    = r_of;
                    n_total = '0;  n_sqtot = '0;  n_count = '0;
                    n_ext   = '0;  n_seen  = 1'b0;
                    n_zf    = 1'b0; n_of   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_sqtot     <= '0;
            r_count     <= '0;
            r_ext       <= '0;
            r_seen      <= 1'b0;
            r_zf        <= 1'b0;
            r_of        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_sqtot     <= n_sqtot;
            r_count     <= n_count;
            r_ext       <= n_ext;
            r_seen      <= n_seen;
            r_zf        <= n_zf;
            r_of        <= n_of;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last  <= n_last;
        r_fmode <= n_fmode;
        r_neg   <= n_neg;
        r_m     <= n_m;
        r_msq   <= n_msq;
        r_acc   <= n_acc;
        r_big   <= n_big;
        r_agg   <= n_agg;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    `SSA_ASSERT_IMP(a_div_start_idle, div_start, !div_busy, "divider started while busy")
    `SSA_ASSERT_IMP(a_sqrt_start_idle, sq_start, !sq_busy, "square root started while busy")
    `SSA_ASSERT_NEXT(a_out_load, (r_state == S_OUT) && !r_out_valid,
        r_out_valid && (r_state == S_IDLE), "result not loaded")
    `SSA_ASSERT_NEXT(a_group_clear, (r_state == S_OUT) && !r_out_valid,
        (r_count == '0) && !r_seen && (r_total == '0) && !r_zf && !r_of,
        "group not cleared after result")

endmodule
`default_nettype wire

[src/streaming_stats_aggregator_core.sv]
// top level of the streaming statistics aggregator
`default_nettype none
// Folds signed Q16.8 samples into the aggregate picked by the mode register
// (sum, min, max, mean, population stddev, sum or mean of reciprocals) and
// emits one Q32.16 result per group on the item marked last. The front takes
// one item per cycle, while the queue has room, into a four-deep queue; the
// back drains it. Sum, mean, min and max items fold in directly, stddev items
// also pass the squaring multiplier, reciprocal items the shared bit-serial
// divider (64 steps), and a zero sample in a reciprocal mode skips the divider.
// At group end mean and mean-of-reciprocals divide once and stddev runs two
// divides, three multiplier passes and a 32-step square root; the aggregate
// then goes into the result register, which waits while the previous result
// is not yet taken. Write the mode only while idle.
module streaming_stats_aggregator_core #(
    parameter int COUNT_BITS = ssa_pkg::COUNT_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_wdata,
    input  wire logic               push,
    output      logic               full,
    input  wire ssa_pkg::t_in_item  i_item,
    output      logic               empty,
    input  wire logic               pop,
    output      ssa_pkg::t_out_item o_result
);
    import ssa_pkg::*;

    // classified item travelling from front to back
    t_entry front_entry;
    t_entry back_entry;
    logic   q_wr;
    logic   q_rd;
    logic   q_full;
    logic   q_empty;
    logic   out_valid;

    // mode register and item classification
    ssa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_item      (i_item),
        .i_q_full    (q_full),
        .o_q_wr      (q_wr),
        .o_entry     (front_entry)
    );

    // decoupling queue, lets the back stall on long divides
    ssa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (front_entry),
        .i_rd    (q_rd),
        .o_rdata (back_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // accumulators, group-end math and the result register
    ssa_back #(.COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (back_entry),
        .i_q_empty   (q_empty),
        .o_q_rd      (q_rd),
        .i_pop       (pop),
        .o_out_valid (out_valid),
        .o_result    (o_result)
    );

    // an input transfer needs queue room; a result transfer needs a loaded result
    assign full  = q_full;
    assign empty = !out_valid;

endmodule
`default_nettype wire

[dv/streaming_stats_aggregator_core_tb.sv]
// self-checking testbench of the streaming statistics aggregator
`timescale 1ns / 100ps
`default_nettype none
module streaming_stats_aggregator_core_tb;
    import ssa_pkg::*;

    localparam int CBITS = 16;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam longint TOT_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint TOT_LO = -TOT_HI - 1;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [2:0] i_cfg_wdata;
    logic       push;
    logic       full;
    t_in_item   i_item;
    logic       empty;
    logic       pop;
    t_out_item  o_result;

    streaming_stats_aggregator_core #(.COUNT_BITS(CBITS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_result(o_result)
    );

    // mirror of the group accumulators
    t_mode       cur_mode;
    longint      acc_total;
    bit [63:0]   acc_sq;
    longint      acc_count;
    longint      acc_extreme;
    bit          acc_seen;
    bit          acc_zero;
    bit          acc_ovf;

    t_out_item   pending_results[$];
    int          mismatch_count;
    longint      cycle_count;
    bit          rx_idle_off;
    bit          tx_idle_off;
    bit          rx_hold;

    always begin
        i_clk = 1'b0; #6;
        i_clk = 1'b1; #6;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic bit [63:0] floor_sqrt(input bit [63:0] v);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit [63:0] magnitude(input longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    task automatic add_to_total(input longint v);
        longint t;
        t = acc_total + v;
        if (t > TOT_HI) begin t = TOT_HI; acc_ovf = 1; end
        if (t < TOT_LO) begin t = TOT_LO; acc_ovf = 1; end
        acc_total = t;
    endtask

    task automatic bump_count();
        if (acc_count < (64'd1 << CBITS) - 1) acc_count++;
        else acc_ovf = 1;
    endtask

    function automatic longint stddev_value();
        bit [63:0] msq, m, a, b, m2, var_q;
        if (acc_count == 0) return 0;
        msq = acc_sq / 64'(acc_count);
        m = magnitude(acc_total / acc_count);
        if (m > (64'd1 << (SAMPLE_BITS + 7))) m = 64'd1 << (SAMPLE_BITS + 7);
        a = m >> 16;
        b = m & 64'hFFFF;
        m2 = ((a * a) << 16) + 2 * a * b + ((b * b) >> 16);
        var_q = msq > m2 ? msq - m2 : 0;
        if (var_q < (64'd1 << 48)) return longint'(floor_sqrt(var_q << 16));
        return longint'(floor_sqrt(var_q) << 8);
    endfunction

    // fold one accepted item into the mirror; queue a result on last
    task automatic predict_item(input t_in_item it);
        longint x;
        longint res;
        bit [63:0] sq;
        t_out_item r;
        x = longint'(it.sample);
        res = 0;
        case (cur_mode)
            MODE_SUM, MODE_MEAN, MODE_STD: begin
                add_to_total(x * 256);
                if (cur_mode != MODE_SUM) bump_count();
                if (cur_mode == MODE_STD) begin
                    sq = magnitude(x) * magnitude(x);
                    if (acc_sq > 64'hFFFF_FFFF_FFFF_FFFF - sq) begin
                        acc_sq = 64'hFFFF_FFFF_FFFF_FFFF;
                        acc_ovf = 1;
                    end else begin
                        acc_sq += sq;
                    end
                end
            end
            MODE_MIN: begin
                if (!acc_seen || x < acc_extreme) acc_extreme = x;
                acc_seen = 1;
            end
            MODE_MAX: begin
                if (!acc_seen || x > acc_extreme) acc_extreme = x;
                acc_seen = 1;
            end
            MODE_RSUM, MODE_RMEAN: begin
                if (x == 0) begin
                    acc_zero = 1;
                end else begin
                    add_to_total((64'sd1 << RECIP_SHIFT) / x);
                    if (cur_mode == MODE_RMEAN) bump_count();
                end
            end
            default: ;
        endcase
        if (!it.last) return;
        case (cur_mode)
            MODE_SUM, MODE_RSUM: res = acc_total;
            MODE_MIN, MODE_MAX: res = acc_seen ? acc_extreme * 256 : 0;
            MODE_MEAN, MODE_RMEAN: res = acc_count != 0 ? acc_total / acc_count : 0;
            MODE_STD: res = stddev_value();
            default: res = 0;
        endcase
        r.aggregate = res[OUT_BITS-1:0];
        r.zero_divisor = acc_zero;
        r.saturated = acc_ovf;
        pending_results = {pending_results, r};
        acc_total = 0; acc_sq = 0; acc_count = 0; acc_extreme = 0;
        acc_seen = 0; acc_zero = 0; acc_ovf = 0;
    endtask

    // result checker with random stalls; rx_hold blocks it for the fill test
    initial begin : result_side
        int stall;
        t_out_item exp_r;
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    report("result transfer with nothing expected");
                end else begin
                    exp_r = pending_results.pop_front();
                    if (o_result.aggregate !== exp_r.aggregate)
                        report($sformatf("aggregate %0h, want %0h",
                                         o_result.aggregate, exp_r.aggregate));
                    if (o_result.zero_divisor !== exp_r.zero_divisor)
                        report($sformatf("zero_divisor %b, want %b",
                                         o_result.zero_divisor, exp_r.zero_divisor));
                    if (o_result.saturated !== exp_r.saturated)
                        report($sformatf("saturated %b, want %b",
                                         o_result.saturated, exp_r.saturated));
                end
            end
            if (rx_hold) begin
                pop <= 1'b0;
            end else if (!rx_idle_off && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                stall = $urandom_range(1, 4);
                repeat (stall) @(posedge i_clk);
                pop <= 1'b1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // one input transfer, with an optional idle burst before it
    task automatic send_item(input logic signed [SAMPLE_BITS-1:0] s, input bit lst);
        t_in_item it;
        if (!tx_idle_off && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        it.sample = s;
        it.last = lst;
        push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        predict_item(it);
    endtask

    // idle point: all results in plus slack for the back end
    task automatic drain();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic set_mode(input t_mode m);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_mode = m;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'sd0;
            3: return SAMPLE_BITS'($urandom_range(0, 3) - 2);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        t_mode m;
        for (int k = 0; k < 8; k++) begin
            m = t_mode'(k);
            set_mode(m);
            send_item(24'sh7FFFFF, 1'b0);
            send_item(24'sh800000, 1'b0);
            send_item(24'sd0, 1'b1);
        end
        // lone last items and an empty-count style group
        set_mode(MODE_RMEAN);
        send_item(24'sd0, 1'b1);
        set_mode(MODE_STD);
        send_item(24'sd1, 1'b1);
    endtask

    // mode change inside a group
    task automatic test_mode_switch();
        set_mode(MODE_SUM);
        send_item(24'sd500, 1'b0);
        set_mode(MODE_MAX);
        send_item(-24'sd3, 1'b0);
        set_mode(MODE_MEAN);
        send_item(24'sd7, 1'b1);
    endtask

    // big groups of extreme values drive the totals far from zero
    task automatic test_saturation();
        set_mode(MODE_SUM);
        for (int k = 0; k < 40; k++) send_item(24'sh7FFFFF, k == 39);
        set_mode(MODE_RSUM);
        for (int k = 0; k < 30; k++) send_item(24'sd1, k == 29);
        set_mode(MODE_STD);
        for (int k = 0; k < 30; k++) send_item((k & 1) ? 24'sh800000 : 24'sh7FFFFF, k == 29);
    endtask

    // receiver holds off while short groups pile up behind it
    task automatic test_fill_stall();
        set_mode(MODE_SUM);
        rx_hold = 1;
        fork
            begin
                int held;
                held = 0;
                while (held < 400) begin @(posedge i_clk); held++; end
                rx_hold = 0;
            end
            begin
                for (int k = 0; k < 30; k++) send_item(rand_sample(), 1'b1);
                push <= 1'b0;
            end
        join
    endtask

    task automatic test_random();
        t_mode m;
        int glen;
        int sent;
        sent = 0;
        while (sent < 250) begin
            if (sent > 200) begin rx_idle_off = 1; tx_idle_off = 1; end
            m = t_mode'($urandom_range(0, 7));
            if (m != cur_mode) set_mode(m);
            glen = (m == MODE_RSUM || m == MODE_RMEAN) ? $urandom_range(1, 5)
                                                       : $urandom_range(1, 12);
            for (int k = 0; k < glen; k++) send_item(rand_sample(), k == glen - 1);
            sent += glen;
        end
    endtask

    initial begin
        mismatch_count = 0;
        cycle_count = 0;
        rx_idle_off = 0; tx_idle_off = 0; rx_hold = 0;
        cur_mode = MODE_SUM;
        acc_total = 0; acc_sq = 0; acc_count = 0; acc_extreme = 0;
        acc_seen = 0; acc_zero = 0; acc_ovf = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        push <= 1'b0;
        i_item <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_mode_switch();
        test_saturation();
        test_fill_stall();
        test_random();
        drain();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
+incdir+src
src/ssa_pkg.sv
src/ssa_front.sv
src/ssa_queue.sv
src/ssa_div.sv
src/ssa_sqrt.sv
src/ssa_back.sv
src/streaming_stats_aggregator_core.sv
dv/streaming_stats_aggregator_core_tb.sv
